// ----- rtl/ptm_pkg.sv -----
`timescale 1ns / 1ps
// Package for the proportional text metrics block: shared types, codes and constants.
// No dependencies; every other file in rtl imports it.
package ptm_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 256;
    localparam int DEFAULT_POS_BITS    = 16;
    localparam int QUEUE_DEPTH         = 2;

    localparam int CODE_BITS  = 8;
    localparam int WIDTH_BITS = 8;

    localparam logic [CODE_BITS-1:0] CODE_CR    = 8'd13;
    localparam logic [CODE_BITS-1:0] CODE_SPACE = 8'd32;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_WRITE   = 1'b1;

    // APB register map
    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;
    localparam logic [1:0] REG_CELL_WIDTH  = 2'd0;
    localparam logic [1:0] REG_CELL_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SPACING     = 2'd2;

    localparam logic [7:0] CELL_WIDTH_RESET  = 8'd8;
    localparam logic [7:0] CELL_HEIGHT_RESET = 8'd8;
    localparam logic [5:0] SPACING_RESET     = 6'd1;

    typedef enum logic [1:0] {
        KIND_NEWLINE,
        KIND_SPACE,
        KIND_GLYPH,
        KIND_ABSENT
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [WIDTH_BITS-1:0] ink;
        logic                  last;
    } ptm_item_t;

    typedef struct packed {
        logic [7:0] cell_width;
        logic [7:0] cell_height;
        logic [5:0] spacing;
    } cfg_t;

endpackage

// ----- rtl/proportional_text_metrics_top.sv -----
`timescale 1ns / 1ps
// Proportional text metrics block, top level: APB register file and the three stages.
// Depends on ptm_pkg, ptm_front, ptm_queue and ptm_back.
//
// The block measures a string one character per transfer on the input channel and returns
// one result transfer per measured character with the pen x, pen y, widest pen x so far and
// text height (pen y plus cell height), all saturating at 2^POS_BITS - 1. Carriage return
// starts a new line, space advances by half the cell width, a glyph marked present in the
// width table advances by spacing plus its ink width, and any other code by the cell width.
// A transfer with op set writes one width table entry and returns nothing. The character
// flagged last ends the string and clears the pen. It takes one transfer per cycle unless
// the front holds a character and the queue is full. A measured character is captured with
// its registered table read, then moves into the two-entry queue, and from there loads the
// output register. The queue lets the front keep taking characters while the output side
// is stalled. Table entries are undefined after reset, so every code that is measured must
// first be written. The cell width, cell height and spacing registers sit at byte addresses
// 0, 4 and 8; the user must write them only while the block is idle, and the block itself
// does not enforce this.
module proportional_text_metrics_top
    import ptm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int POS_BITS    = DEFAULT_POS_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     op,
    input  logic [CODE_BITS-1:0]     code,
    input  logic [WIDTH_BITS-1:0]    glyph_width,
    input  logic                     present,
    input  logic                     last,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [POS_BITS-1:0]      pen_x,
    output logic [POS_BITS-1:0]      pen_y,
    output logic [POS_BITS-1:0]      max_width,
    output logic [POS_BITS-1:0]      text_height,
    output logic                     end_of_string
);

    cfg_t       cfg_reg;
    logic       cfg_wr;
    logic [1:0] reg_idx;

    logic      push, q_full, q_valid, pop;
    ptm_item_t push_item, q_item;

    // Register file. The access completes in the access phase; no wait states.
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cell_width  <= CELL_WIDTH_RESET;
            cfg_reg.cell_height <= CELL_HEIGHT_RESET;
            cfg_reg.spacing     <= SPACING_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_CELL_WIDTH:  cfg_reg.cell_width  <= pwdata[7:0];
                REG_CELL_HEIGHT: cfg_reg.cell_height <= pwdata[7:0];
                REG_SPACING:     cfg_reg.spacing     <= pwdata[5:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_CELL_WIDTH:  prdata = APB_DATA_BITS'(cfg_reg.cell_width);
            REG_CELL_HEIGHT: prdata = APB_DATA_BITS'(cfg_reg.cell_height);
            REG_SPACING:     prdata = APB_DATA_BITS'(cfg_reg.spacing);
            default:         prdata = '0;
        endcase
    end

    // Front end: table writes and the registered table lookup.
    ptm_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .code        (code),
        .glyph_width (glyph_width),
        .present     (present),
        .last        (last),
        .push        (push),
        .push_item   (push_item),
        .q_full      (q_full)
    );

    // Decoupling queue of classified characters.
    ptm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop)
    );

    // Back end: pen arithmetic and the result register.
    ptm_back #(
        .POS_BITS (POS_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pen_x         (pen_x),
        .pen_y         (pen_y),
        .max_width     (max_width),
        .text_height   (text_height),
        .end_of_string (end_of_string)
    );

endmodule

// ----- rtl/ptm_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts input transfers, owns the width table and classifies characters.
// Depends on ptm_pkg; feeds ptm_queue.
module ptm_front
    import ptm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  op,
    input  logic [CODE_BITS-1:0]  code,
    input  logic [WIDTH_BITS-1:0] glyph_width,
    input  logic                  present,
    input  logic                  last,
    output logic                  push,
    output ptm_item_t             push_item,
    input  logic                  q_full
);

    localparam int IDX_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [WIDTH_BITS:0] mem [TABLE_DEPTH];
    logic [WIDTH_BITS:0] rd_data_reg;

    logic s1_valid_reg, s1_valid_next;
    logic s1_cr_reg, s1_space_reg, s1_hit_reg, s1_last_reg;

    logic                in_fire;
    logic                in_range;
    logic [IDX_BITS-1:0] idx;

    assign idx      = code[IDX_BITS-1:0];
    assign in_range = {1'b0, code} < (CODE_BITS + 1)'(TABLE_DEPTH);
    assign push     = s1_valid_reg && !q_full;
    assign in_ready = !s1_valid_reg || !q_full;
    assign in_fire  = in_valid && in_ready;

    // Table write on a write transfer, registered read on a measure transfer.
    always_ff @(posedge clk)
    begin
        if (in_fire && op == OP_WRITE && in_range)
        begin
            mem[idx] <= {present, glyph_width};
        end
        if (in_fire && op == OP_MEASURE)
        begin
            rd_data_reg  <= mem[idx];
            s1_cr_reg    <= (code == CODE_CR);
            s1_space_reg <= (code == CODE_SPACE);
            s1_hit_reg   <= in_range;
            s1_last_reg  <= last;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire && op == OP_MEASURE)
        begin
            s1_valid_next = 1'b1;
        end
        else if (push)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Resolve the character class once the table entry is available.
    always_comb
    begin
        push_item.ink  = rd_data_reg[WIDTH_BITS-1:0];
        push_item.last = s1_last_reg;
        priority if (s1_cr_reg)
        begin
            push_item.kind = KIND_NEWLINE;
        end
        else if (s1_space_reg)
        begin
            push_item.kind = KIND_SPACE;
        end
        else if (s1_hit_reg && rd_data_reg[WIDTH_BITS])
        begin
            push_item.kind = KIND_GLYPH;
        end
        else
        begin
            push_item.kind = KIND_ABSENT;
        end
    end

endmodule

// ----- rtl/ptm_queue.sv -----
`timescale 1ns / 1ps
// Short flop-based queue of classified characters between front and back end.
// Depends on ptm_pkg.
module ptm_queue
    import ptm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  ptm_item_t push_item,
    output logic      full,
    output logic      q_valid,
    output ptm_item_t q_item,
    input  logic      pop
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

    ptm_item_t slot [QUEUE_DEPTH];

    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_FULL);
    assign q_valid = (count_reg != '0);
    assign q_item  = slot[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot[wr_ptr_reg] <= push_item;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/ptm_back.sv -----
`timescale 1ns / 1ps
// Back end: advances the pen state per character and holds the output register.
// Depends on ptm_pkg; drains ptm_queue.
module ptm_back
    import ptm_pkg::*;
#(
    parameter int POS_BITS = DEFAULT_POS_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                q_valid,
    input  ptm_item_t           q_item,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [POS_BITS-1:0] pen_x,
    output logic [POS_BITS-1:0] pen_y,
    output logic [POS_BITS-1:0] max_width,
    output logic [POS_BITS-1:0] text_height,
    output logic                end_of_string
);

    localparam int SUM_BITS = POS_BITS + 2;
    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    logic [POS_BITS-1:0] pen_x_reg, pen_y_reg, max_width_reg;
    logic [POS_BITS-1:0] out_x_reg, out_y_reg, out_max_reg, out_h_reg;
    logic                out_end_reg, out_valid_reg;

    logic [SUM_BITS-1:0] adv, base, sum, h_sum;
    logic [POS_BITS-1:0] sat, new_x, new_y, new_max, new_h;
    logic                is_nl;

    assign pop   = q_valid && (!out_valid_reg || out_ready);
    assign is_nl = (q_item.kind == KIND_NEWLINE);

    always_comb
    begin
        unique case (q_item.kind)
            KIND_NEWLINE: adv = SUM_BITS'(cfg.cell_height) + SUM_BITS'(cfg.spacing);
            KIND_SPACE:   adv = SUM_BITS'(cfg.cell_width[7:1]);
            KIND_GLYPH:   adv = SUM_BITS'(cfg.spacing) + SUM_BITS'(q_item.ink);
            KIND_ABSENT:  adv = SUM_BITS'(cfg.cell_width);
            default:      adv = '0;
        endcase
        base    = SUM_BITS'(is_nl ? pen_y_reg : pen_x_reg);
        sum     = base + adv;
        sat     = (sum > SUM_BITS'(POS_MAX)) ? POS_MAX : sum[POS_BITS-1:0];
        new_x   = is_nl ? '0 : sat;
        new_y   = is_nl ? sat : pen_y_reg;
        new_max = (new_x > max_width_reg) ? new_x : max_width_reg;
        h_sum   = SUM_BITS'(new_y) + SUM_BITS'(cfg.cell_height);
        new_h   = (h_sum > SUM_BITS'(POS_MAX)) ? POS_MAX : h_sum[POS_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_x_reg   <= new_x;
            out_y_reg   <= new_y;
            out_max_reg <= new_max;
            out_h_reg   <= new_h;
            out_end_reg <= q_item.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            max_width_reg <= '0;
        end
        else
        begin
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pop)
            begin
                // The final character of a string clears the pen for the next one.
                pen_x_reg     <= q_item.last ? '0 : new_x;
                pen_y_reg     <= q_item.last ? '0 : new_y;
                max_width_reg <= q_item.last ? '0 : new_max;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign pen_x         = out_x_reg;
    assign pen_y         = out_y_reg;
    assign max_width     = out_max_reg;
    assign text_height   = out_h_reg;
    assign end_of_string = out_end_reg;

endmodule

// ----- rtl/ptm_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks on the result channel of the text metrics block, and their bind.
// Depends on ptm_pkg and proportional_text_metrics_top.
module ptm_checker
    import ptm_pkg::*;
#(
    parameter int POS_BITS = DEFAULT_POS_BITS
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [POS_BITS-1:0] pen_x,
    input logic [POS_BITS-1:0] pen_y,
    input logic [POS_BITS-1:0] max_width,
    input logic [POS_BITS-1:0] text_height
);

    // A stalled result transfer keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pen_x) && $stable(pen_y)
            && $stable(max_width) && $stable(text_height))
        else $error("result changed while stalled");

    // The widest pen position of a string never falls below the current one.
    a_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> max_width >= pen_x)
        else $error("max_width below pen_x");

    // Text height is a saturating sum on top of pen y.
    a_height: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> text_height >= pen_y)
        else $error("text_height below pen_y");

    // No result is offered in the cycle after reset was seen held.
    a_reset: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result offered during reset");

endmodule

bind proportional_text_metrics_top ptm_checker #(
    .POS_BITS (POS_BITS)
) u_ptm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pen_x       (pen_x),
    .pen_y       (pen_y),
    .max_width   (max_width),
    .text_height (text_height)
);

// ----- verif/ptm_metrics_checker.sv -----
`timescale 1ns / 1ps
// Checker for the proportional text metrics block: watches the APB port and both channels,
// predicts the metrics of each measured character and compares every result transfer.
// Depends on ptm_pkg for the register map, the op codes and the special character codes.
module ptm_metrics_checker
    import ptm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int POS_BITS    = DEFAULT_POS_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    input  logic                     pready,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic                     op,
    input  logic [CODE_BITS-1:0]     code,
    input  logic [WIDTH_BITS-1:0]    glyph_width,
    input  logic                     present,
    input  logic                     last,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic [POS_BITS-1:0]      pen_x,
    input  logic [POS_BITS-1:0]      pen_y,
    input  logic [POS_BITS-1:0]      max_width,
    input  logic [POS_BITS-1:0]      text_height,
    input  logic                     end_of_string,
    output int                       mismatches,
    output int                       outstanding
);

    localparam int POS_MAX = (1 << POS_BITS) - 1;

    typedef struct packed {
        logic [POS_BITS-1:0] x;
        logic [POS_BITS-1:0] y;
        logic [POS_BITS-1:0] widest;
        logic [POS_BITS-1:0] height;
        logic                done;
    } metrics_t;

    // Shadow of the width table: bit 8 is the present flag, bits 7:0 the ink width.
    logic [8:0] glyph_table [TABLE_DEPTH];
    int         cur_x;
    int         cur_y;
    int         widest_x;
    logic [7:0] cell_w;
    logic [7:0] cell_h;
    logic [5:0] gap_px;
    metrics_t   expected_metrics[$];

    function automatic int sat_sum(input int a, input int b);
        int s;
        s = a + b;
        return (s > POS_MAX) ? POS_MAX : s;
    endfunction

    task automatic predict_metrics(input logic [CODE_BITS-1:0] ch, input logic fin,
                                   output metrics_t m);
        logic [8:0] entry;
        entry = 9'd0;
        if (ch == CODE_CR) begin
            cur_y = sat_sum(cur_y, int'(cell_h) + int'(gap_px));
            cur_x = 0;
        end
        else if (ch == CODE_SPACE) begin
            cur_x = sat_sum(cur_x, int'(cell_w >> 1));
        end
        else begin
            if (int'(ch) < TABLE_DEPTH)
                entry = glyph_table[ch];
            if (entry[8])
                cur_x = sat_sum(cur_x, int'(gap_px) + int'(entry[7:0]));
            else
                cur_x = sat_sum(cur_x, int'(cell_w));
        end
        if (cur_x > widest_x)
            widest_x = cur_x;
        m.x      = cur_x[POS_BITS-1:0];
        m.y      = cur_y[POS_BITS-1:0];
        m.widest = widest_x[POS_BITS-1:0];
        m.height = POS_BITS'(sat_sum(cur_y, int'(cell_h)));
        m.done   = fin;
        // The string is over: the pen starts again from the origin.
        if (fin) begin
            cur_x    = 0;
            cur_y    = 0;
            widest_x = 0;
        end
    endtask

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned seen);
        if (want != seen) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, seen);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        metrics_t want;
        if (!rst_n) begin
            cur_x       = 0;
            cur_y       = 0;
            widest_x    = 0;
            cell_w      = CELL_WIDTH_RESET;
            cell_h      = CELL_HEIGHT_RESET;
            gap_px      = SPACING_RESET;
            mismatches  = 0;
            expected_metrics.delete();
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_CELL_WIDTH:  cell_w = pwdata[7:0];
                    REG_CELL_HEIGHT: cell_h = pwdata[7:0];
                    REG_SPACING:     gap_px = pwdata[5:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready) begin
                if (expected_metrics.size() == 0) begin
                    $error("result transfer with no expected metrics pending");
                    mismatches++;
                end
                else begin
                    want = expected_metrics.pop_front();
                    check_field("pen_x", 32'(want.x), 32'(pen_x));
                    check_field("pen_y", 32'(want.y), 32'(pen_y));
                    check_field("max_width", 32'(want.widest), 32'(max_width));
                    check_field("text_height", 32'(want.height), 32'(text_height));
                    check_field("end_of_string", 32'(want.done), 32'(end_of_string));
                end
            end
            if (in_valid && in_ready) begin
                if (op == OP_WRITE) begin
                    if (int'(code) < TABLE_DEPTH)
                        glyph_table[code] = {present, glyph_width};
                end
                else begin
                    predict_metrics(code, last, want);
                    expected_metrics.push_back(want);
                end
            end
        end
        outstanding = expected_metrics.size();
    end

endmodule

// ----- verif/proportional_text_metrics_top_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for the proportional text metrics block: clock, reset, APB setup, character
// stimulus with bursty input and a stalling receiver, and the final verdict.
// Depends on ptm_pkg, proportional_text_metrics_top and ptm_metrics_checker.
module proportional_text_metrics_top_tb;
    import ptm_pkg::*;

    // Number of random items per configuration phase and number of phases.
    localparam int PHASE_ITEMS = 130;
    localparam int PHASES      = 7;
    // Length of the one long receiver hold-off, in cycles. It is well beyond the depth of
    // the block's pipeline and queue, so the input side must stall.
    localparam int LONG_HOLD   = 64;
    localparam int POS_BITS    = DEFAULT_POS_BITS;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     in_valid;
    logic                     in_ready;
    logic                     op;
    logic [CODE_BITS-1:0]     code;
    logic [WIDTH_BITS-1:0]    glyph_width;
    logic                     present;
    logic                     last;
    logic                     out_valid;
    logic                     out_ready;
    logic [POS_BITS-1:0]      pen_x;
    logic [POS_BITS-1:0]      pen_y;
    logic [POS_BITS-1:0]      max_width;
    logic [POS_BITS-1:0]      text_height;
    logic                     end_of_string;

    int mismatches;
    int outstanding;

    // Stimulus bookkeeping. Codes that have a written table entry are the only ones that
    // may be measured, apart from carriage return and space, whose table entry is ignored.
    int                   items_sent   = 0;
    int                   burst_left   = 0;
    bit                   steady_feed  = 1'b0;
    bit                   hold_request = 1'b0;
    bit                   written [256];
    logic [CODE_BITS-1:0] known_codes[$];

    proportional_text_metrics_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .code          (code),
        .glyph_width   (glyph_width),
        .present       (present),
        .last          (last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pen_x         (pen_x),
        .pen_y         (pen_y),
        .max_width     (max_width),
        .text_height   (text_height),
        .end_of_string (end_of_string)
    );

    ptm_metrics_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .code          (code),
        .glyph_width   (glyph_width),
        .present       (present),
        .last          (last),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pen_x         (pen_x),
        .pen_y         (pen_y),
        .max_width     (max_width),
        .text_height   (text_height),
        .end_of_string (end_of_string),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run. A correct run with the slowest receiver pattern and the
    // longest sender gaps stays far below this.
    initial
    begin
        #5000000;
        $display("proportional_text_metrics_top_tb: FAIL");
        $finish;
    end

    // Receiver. It changes out_ready only at falling edges, in segments of random length:
    // always ready, coin toss, mostly stalled, or mostly ready. When the stimulus asks for
    // it, the receiver holds off completely for one long hold-off, counted down here.
    initial
    begin
        int mode;
        int seg_left;
        int hold_left;
        mode      = 0;
        seg_left  = 0;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else begin
                if (seg_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    seg_left = $urandom_range(1, 40);
                end
                seg_left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 9) == 0);
                    default: out_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // One input transfer. The sender works in bursts: at the start of each burst it may
    // drop valid for a random gap, unless a steady feed is requested. Valid stays high from
    // one item to the next inside a burst, so it is never lowered and raised in one step.
    task automatic send_item(input logic op_v, input logic [CODE_BITS-1:0] code_v,
                             input logic [WIDTH_BITS-1:0] width_v, input logic present_v,
                             input logic last_v);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!steady_feed && $urandom_range(0, 2) != 0) begin
                gap = $urandom_range(1, 8);
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid    <= 1'b1;
        op          <= op_v;
        code        <= code_v;
        glyph_width <= width_v;
        present     <= present_v;
        last        <= last_v;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Drop valid after the last accepted transfer so that no item is offered twice.
    task automatic idle_input();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
    endtask

    // Table write. The last flag of a write is meaningless to the block, so its value is arbitrary.
    task automatic write_entry(input logic [CODE_BITS-1:0] idx, input logic [WIDTH_BITS-1:0] w,
                               input logic pres, input logic fin);
        send_item(OP_WRITE, idx, w, pres, fin);
        if (!written[idx]) begin
            written[idx] = 1'b1;
            known_codes.push_back(idx);
        end
    endtask

    task automatic write_random_entry();
        write_entry(8'($urandom), 8'($urandom), ($urandom_range(0, 9) < 7),
                    1'($urandom_range(0, 1)));
    endtask

    // Measure transfer. The width and present fields are unused here and carry noise.
    task automatic measure(input logic [CODE_BITS-1:0] ch, input logic fin);
        send_item(OP_MEASURE, ch, 8'($urandom), 1'($urandom_range(0, 1)), fin);
    endtask

    // A string of characters drawn from carriage returns, spaces and codes with a known
    // table entry. An occasional table write lands in the middle of the string. A string
    // that is not closed simply runs on into the next one.
    task automatic send_string(input int len, input int cr_pct, input int space_pct,
                               input bit closed);
        logic [CODE_BITS-1:0] ch;
        int                   roll;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 3)
                write_random_entry();
            roll = $urandom_range(0, 99);
            if (roll < cr_pct)
                ch = CODE_CR;
            else if (roll < cr_pct + space_pct)
                ch = CODE_SPACE;
            else
                ch = known_codes[$urandom_range(0, known_codes.size() - 1)];
            measure(ch, closed && (i == len - 1));
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [7:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Change the layout registers only with the block idle: every expected result must
    // have arrived, and a few more cycles let any trailing table write settle.
    task automatic set_layout(input logic [7:0] cw, input logic [7:0] ch,
                              input logic [5:0] sp);
        idle_input();
        wait (outstanding == 0);
        repeat (6) @(posedge clk);
        apb_write(REG_CELL_WIDTH, cw);
        apb_write(REG_CELL_HEIGHT, ch);
        apb_write(REG_SPACING, {2'b00, sp});
    endtask

    // Random text: mostly short well-formed strings, some table writes, a few strings left
    // open, and now and then a long string that drives the pen toward saturation.
    task automatic run_random_text(input int count);
        int stop_at;
        int pick;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                repeat ($urandom_range(1, 4)) write_random_entry();
            else if (pick < 9)
                send_string($urandom_range(150, 300), ($urandom_range(0, 1) != 0) ? 0 : 90,
                            5, 1'b1);
            else
                send_string($urandom_range(1, 12), 12, 12, ($urandom_range(0, 19) != 0));
        end
    endtask

    // Main stimulus.
    initial
    begin
        logic [7:0] cw;
        logic [7:0] ch;
        logic [5:0] sp;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        op          = OP_MEASURE;
        code        = '0;
        glyph_width = '0;
        present     = 1'b0;
        last        = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part with the reset layout (cell 8 by 8, spacing 1). Code zero and line
        // feed are ordinary glyphs; carriage return and space get table entries that must
        // be ignored; two glyphs are absent, one with a width that must not be used.
        write_entry(8'd0, 8'd255, 1'b1, 1'b1);
        write_entry(8'd10, 8'd0, 1'b1, 1'b0);
        write_entry(8'd65, 8'd7, 1'b1, 1'b0);
        write_entry(8'd255, 8'd0, 1'b0, 1'b1);
        write_entry(8'd128, 8'd200, 1'b0, 1'b0);
        write_entry(CODE_CR, 8'd99, 1'b1, 1'b0);
        write_entry(CODE_SPACE, 8'd99, 1'b1, 1'b0);
        measure(8'd0, 1'b0);
        measure(8'd10, 1'b0);
        measure(8'd65, 1'b0);
        measure(CODE_SPACE, 1'b0);
        measure(8'd255, 1'b0);
        measure(8'd128, 1'b0);
        measure(CODE_CR, 1'b0);
        measure(8'd65, 1'b0);
        measure(CODE_CR, 1'b1);
        // Strings of a single character, then a glyph rewritten as absent.
        measure(8'd65, 1'b1);
        measure(CODE_SPACE, 1'b1);
        write_entry(8'd65, 8'd1, 1'b0, 1'b0);
        measure(8'd65, 1'b1);

        // Spread some table entries before the random text starts.
        repeat (48) write_random_entry();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin cw = 8'd255; ch = 8'd255; sp = 6'd63; end
                1: begin cw = 8'd1;   ch = 8'd1;   sp = 6'd0;  end
                2: begin cw = 8'd0;   ch = 8'd0;   sp = 6'd63; end
                default: begin
                    cw = 8'($urandom_range(1, 255));
                    ch = 8'($urandom_range(1, 255));
                    sp = 6'($urandom_range(0, 63));
                end
            endcase
            set_layout(cw, ch, sp);
            if (p == 0) begin
                // With the largest layout, one long line saturates pen x and max width,
                // and a run of carriage returns saturates pen y and text height.
                send_string(400, 0, 5, 1'b1);
                send_string(260, 90, 0, 1'b1);
            end
            if (p == 1) begin
                // The receiver holds off while the sender keeps offering characters
                // back to back, so the block fills up and stalls its input.
                hold_request = 1'b1;
                steady_feed  = 1'b1;
                send_string(60, 10, 10, 1'b1);
                steady_feed  = 1'b0;
            end
            run_random_text(PHASE_ITEMS);
        end

        idle_input();
        wait (outstanding == 0);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("proportional_text_metrics_top_tb: PASS");
        else
            $display("proportional_text_metrics_top_tb: FAIL");
        $finish;
    end

endmodule
